// ----- hdl/glgs_pkg.sv -----
package glgs_pkg;

	localparam int BIO_W = 24;
	localparam int FX_W  = 16;
	localparam int TD_W  = 17;
	localparam int KP_W  = 26;
	localparam int RF_W  = 18;
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;

	localparam logic [BIO_W-1:0] BIO_MAX = 24'hFFFFFF;
	localparam logic [BIO_W-1:0] BIO_RST = 24'd1048;

	typedef enum logic [IDX_W-1:0] {
		REG_TEMP     = 3'd0,
		REG_DROUGHT  = 3'd1,
		REG_MAX_CAP  = 3'd2,
		REG_MAX_RATE = 3'd3,
		REG_SHADE    = 3'd4,
		REG_MIN_BIO  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [TD_W-1:0]  td;
		logic [CFG_W-1:0] max_capacity;
		logic [FX_W-1:0]  max_growth_rate;
		logic [2:0]       shade;
	} glgs_cfg_t;

	typedef struct packed {
		logic             in_grid;
		logic [FX_W-1:0]  resp;
		logic [KP_W-1:0]  kpot;
		logic [RF_W-1:0]  reff;
	} glgs_job_t;

endpackage

// ----- hdl/glgs_front.sv -----
module glgs_front #(
	parameter int GRID_SIDE = 64,
	parameter int AW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_acc,
	input  logic [5:0]           cell_row,
	input  logic [5:0]           cell_col,
	input  logic [15:0]          light_level,
	input  glgs_pkg::glgs_cfg_t  cfg,
	output logic                 job_vld,
	output logic [AW-1:0]        job_addr,
	output glgs_pkg::glgs_job_t  job
);
	import glgs_pkg::*;

	localparam logic signed [17:0] OFS_INTOL   = 18'sd4915;
	localparam logic signed [17:0] OFS_TOL     = 18'sd983;
	localparam logic signed [39:0] SLOPE_INTOL = 40'sd54838;
	localparam logic signed [39:0] SLOPE_TOL   = 40'sd217461;
	localparam logic signed [39:0] GAIN_INTOL  = 40'sd52429;
	localparam logic signed [39:0] GAIN_TOL    = 40'sd33115;
	localparam logic signed [39:0] EXP_BIAS    = 40'sd4294967296;

	function automatic logic [15:0] pow2_frac(input logic [4:0] i);
		logic [15:0] r;
		unique case (i)
			5'd0:  r = 16'd32768;
			5'd1:  r = 16'd31379;
			5'd2:  r = 16'd30048;
			5'd3:  r = 16'd28774;
			5'd4:  r = 16'd27554;
			5'd5:  r = 16'd26386;
			5'd6:  r = 16'd25268;
			5'd7:  r = 16'd24196;
			5'd8:  r = 16'd23170;
			5'd9:  r = 16'd22188;
			5'd10: r = 16'd21247;
			5'd11: r = 16'd20347;
			5'd12: r = 16'd19484;
			5'd13: r = 16'd18658;
			5'd14: r = 16'd17867;
			5'd15: r = 16'd17109;
			default: r = 16'd16384;
		endcase
		return r;
	endfunction

	// exponent in Q.15 log2 units, floored at zero: {int[4:0], idx[3:0], rem[10:0]}
	function automatic logic [19:0] curve_split(input logic signed [39:0] p);
		logic [19:0] r;
		if (p < 0) r = '0;
		else r = p[34:15];
		return r;
	endfunction

	function automatic logic [19:0] curve_exp(input logic [19:0] sp);
		logic [4:0]  n;
		logic [4:0]  idx;
		logic [10:0] rem;
		logic [15:0] t0;
		logic [15:0] t1;
		logic [10:0] dl;
		logic [21:0] pr;
		logic [15:0] v;
		logic [19:0] e;
		n   = sp[19:15];
		idx = {1'b0, sp[14:11]};
		rem = sp[10:0];
		t0  = pow2_frac(idx);
		t1  = pow2_frac(idx + 5'd1);
		dl  = 11'(t0 - t1);
		pr  = 22'(dl) * 22'(rem);
		v   = t0 - 16'(pr[21:11]);
		if (n <= 5'd4) e = 20'(v) << (5'd4 - n);
		else if (n > 5'd24) e = '0;
		else e = 20'(v) >> (n - 5'd4);
		return e;
	endfunction

	function automatic logic signed [39:0] curve_gain(input logic [19:0] e,
			input logic signed [39:0] gain);
		logic signed [39:0] sub;
		sub = 40'sd32768 - $signed({20'b0, e});
		return sub * gain;
	endfunction

	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [AW-1:0]       addr_s1, addr_s2, addr_s3, addr_s4, addr_s5, addr_s6;
	logic                ing_s1, ing_s2, ing_s3, ing_s4, ing_s5, ing_s6;
	logic [19:0]         sp_i_s1, sp_t_s1;
	logic [19:0]         e_i_s2, e_t_s2;
	logic signed [39:0]  a_i_s3, a_t_s3;
	logic [FX_W-1:0]     resp_s4, resp_s5, resp_s6;
	logic [TD_W-1:0]     env_s5;
	logic [KP_W-1:0]     kpot_s6;
	logic [RF_W-1:0]     reff_s6;

	logic signed [17:0]  d_i_c, d_t_c;
	logic signed [39:0]  p_i_c, p_t_c;
	logic [AW-1:0]       addr_c;
	logic                ing_c;
	logic [2:0]          w_c;
	logic signed [39:0]  raw_c;
	logic [22:0]         r_c;
	logic [FX_W-1:0]     resp_c;
	logic [32:0]         ep_c;
	logic [40:0]         kp_c;
	logic [32:0]         rf_c;

	always_comb begin
		d_i_c  = $signed({2'b00, light_level}) - OFS_INTOL;
		d_t_c  = $signed({2'b00, light_level}) - OFS_TOL;
		p_i_c  = 40'(d_i_c) * SLOPE_INTOL + EXP_BIAS;
		p_t_c  = 40'(d_t_c) * SLOPE_TOL + EXP_BIAS;
		addr_c = AW'(32'(cell_row) * GRID_SIDE + 32'(cell_col));
		ing_c  = (32'(cell_row) < GRID_SIDE) && (32'(cell_col) < GRID_SIDE);
	end

	// blend by shade class: (5-w)*a + (w-1)*b
	always_comb begin
		w_c = cfg.shade;
		if (w_c == 3'd0) w_c = 3'd1;
		else if (w_c > 3'd5) w_c = 3'd5;
		unique case (w_c)
			3'd1: raw_c = a_i_s3 <<< 2;
			3'd2: raw_c = (a_i_s3 <<< 1) + a_i_s3 + a_t_s3;
			3'd3: raw_c = (a_i_s3 <<< 1) + (a_t_s3 <<< 1);
			3'd4: raw_c = a_i_s3 + (a_t_s3 <<< 1) + a_t_s3;
			default: raw_c = a_t_s3 <<< 2;
		endcase
		r_c = raw_c[39:17];
		if (raw_c <= 0) resp_c = '0;
		else if (r_c > 23'd32768) resp_c = 16'd32768;
		else resp_c = r_c[15:0];
		ep_c = 33'(cfg.td) * 33'(resp_s4);
		kp_c = 41'(cfg.max_capacity) * 41'(env_s5);
		rf_c = 33'(cfg.max_growth_rate) * 33'(env_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_c;
		ing_s1  <= ing_c;
		sp_i_s1 <= curve_split(p_i_c);
		sp_t_s1 <= curve_split(p_t_c);
		addr_s2 <= addr_s1;
		ing_s2  <= ing_s1;
		e_i_s2  <= curve_exp(sp_i_s1);
		e_t_s2  <= curve_exp(sp_t_s1);
		addr_s3 <= addr_s2;
		ing_s3  <= ing_s2;
		a_i_s3  <= curve_gain(e_i_s2, GAIN_INTOL);
		a_t_s3  <= curve_gain(e_t_s2, GAIN_TOL);
		addr_s4 <= addr_s3;
		ing_s4  <= ing_s3;
		resp_s4 <= resp_c;
		addr_s5 <= addr_s4;
		ing_s5  <= ing_s4;
		resp_s5 <= resp_s4;
		env_s5  <= ep_c[31:15];
		addr_s6 <= addr_s5;
		ing_s6  <= ing_s5;
		resp_s6 <= resp_s5;
		kpot_s6 <= kp_c[40:15];
		reff_s6 <= rf_c[32:15];
	end

	assign job_vld      = v_s6;
	assign job_addr     = addr_s6;
	assign job.in_grid  = ing_s6;
	assign job.resp     = resp_s6;
	assign job.kpot     = kpot_s6;
	assign job.reff     = reff_s6;

endmodule

// ----- hdl/glgs_fifo.sv -----
module glgs_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         rd_vld
);
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign rd_vld  = (cnt_q != '0);

endmodule

// ----- hdl/glgs_back.sv -----
module glgs_back #(
	parameter int N = 4096,
	parameter int AW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_vld,
	input  logic [AW-1:0]        job_addr,
	input  glgs_pkg::glgs_job_t  job,
	input  logic [23:0]          min_biomass,
	output logic                 issue,
	output logic                 clearing,
	output logic                 out_vld,
	input  logic                 pop,
	output logic [23:0]          new_biomass,
	output logic [15:0]          light_response
);
	import glgs_pkg::*;

	localparam int DVD_W = 50;
	localparam int QS_W  = 40;
	localparam int LAT   = DVD_W + 4;

	typedef struct packed {
		logic [BIO_W-1:0] b;
		logic [RF_W-1:0]  reff;
		logic             neg;
		logic             kzero;
		logic [FX_W-1:0]  resp;
		logic [KP_W-1:0]  d;
	} pay_t;

	logic [BIO_W-1:0] mem [N];
	logic             clr_q;
	logic [AW-1:0]    clr_cnt_q;

	logic             tag_v_q [LAT];
	logic             tag_g_q [LAT];
	logic [AW-1:0]    tag_a_q [LAT];

	logic [BIO_W-1:0] bio_s1;
	glgs_job_t        job_s1;
	logic [DVD_W-1:0] dv_dvd_s [DVD_W+1];
	logic [DVD_W-1:0] dv_quo_s [DVD_W+1];
	logic [KP_W-1:0]  dv_rem_s [DVD_W+1];
	pay_t             pay_s    [DVD_W+1];
	logic [37:0]      ph_sm1, pl_sm1;
	pay_t             pay_sm1;
	logic [42:0]      delta_sm2;
	pay_t             pay_sm2;

	logic             out_vld_q;
	logic [BIO_W-1:0] out_bio_q;
	logic [FX_W-1:0]  out_resp_q;

	logic             adv, hazard, wb;
	logic signed [26:0] diff_c;
	logic [KP_W-1:0]  mag_c;
	logic [QS_W-1:0]  qs_c;
	logic [57:0]      sum_c;
	logic signed [45:0] nb_raw_c;
	logic [BIO_W-1:0] nb_c;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [BIO_W-1:0] mem_wd;

	assign adv = !out_vld_q || pop;

	// same cell still in flight: hold it until the earlier write lands
	always_comb begin
		hazard = 1'b0;
		for (int i = 0; i < LAT; i++) begin
			if (tag_v_q[i] && tag_g_q[i] && tag_a_q[i] == job_addr) hazard = 1'b1;
		end
	end

	assign issue    = adv && job_vld && !clr_q && !(job.in_grid && hazard);
	assign clearing = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(N - 1)) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) tag_v_q[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			tag_v_q[0] <= issue;
			for (int i = 1; i < LAT; i++) tag_v_q[i] <= tag_v_q[i-1];
			out_vld_q <= tag_v_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_g_q[0] <= job.in_grid;
			tag_a_q[0] <= job_addr;
			for (int i = 1; i < LAT; i++) begin
				tag_g_q[i] <= tag_g_q[i-1];
				tag_a_q[i] <= tag_a_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (issue && job.in_grid) bio_s1 <= mem[job_addr];
	end

	always_ff @(posedge clk) begin
		if (adv) job_s1 <= job;
	end

	always_comb begin
		diff_c = $signed({1'b0, job_s1.kpot}) - $signed({3'b000, bio_s1});
		mag_c  = diff_c[26] ? KP_W'(-diff_c) : KP_W'(diff_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_dvd_s[0]     <= DVD_W'(mag_c) * DVD_W'(bio_s1);
			dv_rem_s[0]     <= '0;
			dv_quo_s[0]     <= '0;
			pay_s[0].b      <= bio_s1;
			pay_s[0].reff   <= job_s1.reff;
			pay_s[0].neg    <= diff_c[26];
			pay_s[0].kzero  <= (job_s1.kpot == '0);
			pay_s[0].resp   <= job_s1.resp;
			pay_s[0].d      <= job_s1.kpot;
		end
	end

	// restoring divide, one quotient bit per stage, MSB first
	for (genvar k = 1; k <= DVD_W; k++) begin : g_div
		logic [KP_W:0] r2;
		logic          ge;
		always_comb begin
			r2 = {dv_rem_s[k-1], dv_dvd_s[k-1][DVD_W-1]};
			ge = (r2 >= {1'b0, pay_s[k-1].d});
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[k] <= ge ? KP_W'(r2 - {1'b0, pay_s[k-1].d}) : r2[KP_W-1:0];
				dv_dvd_s[k] <= dv_dvd_s[k-1] << 1;
				dv_quo_s[k] <= {dv_quo_s[k-1][DVD_W-2:0], ge};
				pay_s[k]    <= pay_s[k-1];
			end
		end
	end

	// quotients past 2^39 already push the result to a clamp
	always_comb begin
		if (|dv_quo_s[DVD_W][DVD_W-1:QS_W-1]) qs_c = {1'b1, {(QS_W-1){1'b0}}};
		else qs_c = dv_quo_s[DVD_W][QS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_sm1  <= 38'(qs_c[39:20]) * 38'(pay_s[DVD_W].reff);
			pl_sm1  <= 38'(qs_c[19:0]) * 38'(pay_s[DVD_W].reff);
			pay_sm1 <= pay_s[DVD_W];
		end
	end

	assign sum_c = {ph_sm1, 20'b0} + 58'(pl_sm1);

	always_ff @(posedge clk) begin
		if (adv) begin
			delta_sm2 <= sum_c[57:15];
			pay_sm2   <= pay_sm1;
		end
	end

	always_comb begin
		if (pay_sm2.kzero) nb_raw_c = $signed(46'(pay_sm2.b));
		else if (pay_sm2.neg) nb_raw_c = $signed(46'(pay_sm2.b)) - $signed(46'(delta_sm2));
		else nb_raw_c = $signed(46'(pay_sm2.b)) + $signed(46'(delta_sm2));
		if (nb_raw_c < 0) nb_c = '0;
		else if (nb_raw_c > $signed(46'(BIO_MAX))) nb_c = BIO_MAX;
		else nb_c = nb_raw_c[BIO_W-1:0];
		if (nb_c < min_biomass) nb_c = min_biomass;
	end

	assign wb     = adv && tag_v_q[LAT-1] && tag_g_q[LAT-1];
	assign mem_we = clr_q || wb;
	assign mem_wa = clr_q ? clr_cnt_q : tag_a_q[LAT-1];
	assign mem_wd = clr_q ? BIO_RST : nb_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_bio_q  <= tag_g_q[LAT-1] ? nb_c : '0;
			out_resp_q <= pay_sm2.resp;
		end
	end

	assign out_vld        = out_vld_q;
	assign new_biomass    = out_bio_q;
	assign light_response = out_resp_q;

endmodule

// ----- hdl/grid_logistic_growth_step_top.sv -----
// Grid logistic growth step.
// Input queue side: cell_row, cell_col, light_level go in on push while full is low.
// Result queue side: new_biomass, light_response are valid while empty is low and
// leave on pop. One result per input transaction, in input order.
// Config: cfg_wr_en/cfg_idx/cfg_wdata write one register per cycle; write only while idle.
// Throughput: one transaction per cycle while no stall holds the flow. With no stalls the
// result reaches the ports through the capture register, 5 more light-response front
// stages, the job queue register, the back end (biomass read, dividend multiply,
// 50-stage restoring divider, two multiply/add stages) and the output register.
// Two transactions on the same cell closer than the back-end depth
// stall the second at the queue head until the first has written its biomass back.
// After reset the biomass store is filled with the reset floor, one cell per cycle;
// full stays high during that pass.
// When pop is held low, the back end freezes once a result waits; full rises when the front
// pipeline and the 16-entry job queue hold 16 transactions together; none is lost.
module grid_logistic_growth_step_top #(
	parameter int GRID_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [5:0]  cell_row,
	input  logic [5:0]  cell_col,
	input  logic [15:0] light_level,
	output logic        empty,
	input  logic        pop,
	output logic [23:0] new_biomass,
	output logic [15:0] light_response,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_wdata
);
	import glgs_pkg::*;

	localparam int N      = GRID_SIDE * GRID_SIDE;
	localparam int AW     = (N > 1) ? $clog2(N) : 1;
	localparam int JW     = $bits(glgs_job_t);
	localparam int QDEPTH = 16;
	localparam int CW     = $clog2(QDEPTH) + 1;

	logic [15:0]      temp_q, drought_q, mgr_q;
	logic [CFG_W-1:0] maxcap_q;
	logic [2:0]       shade_q;
	logic [BIO_W-1:0] minb_q;
	logic [TD_W-1:0]  td_q;
	logic [31:0]      td_c;
	glgs_cfg_t        cfg;

	logic             acc;
	logic             fr_vld;
	logic [AW-1:0]    fr_addr;
	glgs_job_t        fr_job;
	logic [AW+JW-1:0] fq_data;
	logic             fq_vld;
	logic             issue, clearing, out_vld;
	logic [CW-1:0]    cred_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q    <= 16'd32768;
			drought_q <= 16'd32768;
			maxcap_q  <= 24'd1048576;
			mgr_q     <= 16'd32768;
			shade_q   <= 3'd1;
			minb_q    <= BIO_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TEMP:     temp_q    <= cfg_wdata[15:0];
				REG_DROUGHT:  drought_q <= cfg_wdata[15:0];
				REG_MAX_CAP:  maxcap_q  <= cfg_wdata;
				REG_MAX_RATE: mgr_q     <= cfg_wdata[15:0];
				REG_SHADE:    shade_q   <= cfg_wdata[2:0];
				REG_MIN_BIO:  minb_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign td_c = 32'(temp_q) * 32'(drought_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) td_q <= 17'd32768;
		else td_q <= td_c[31:15];
	end

	assign cfg.td              = td_q;
	assign cfg.max_capacity    = maxcap_q;
	assign cfg.max_growth_rate = mgr_q;
	assign cfg.shade           = shade_q;

	// credits cover the front pipeline plus the job queue
	assign full = clearing || (cred_q == CW'(QDEPTH));
	assign acc  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cred_q <= '0;
		else if (acc && !issue) cred_q <= cred_q + 1'b1;
		else if (!acc && issue) cred_q <= cred_q - 1'b1;
	end

	glgs_front #(.GRID_SIDE(GRID_SIDE), .AW(AW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (acc),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.light_level (light_level),
		.cfg         (cfg),
		.job_vld     (fr_vld),
		.job_addr    (fr_addr),
		.job         (fr_job)
	);

	glgs_fifo #(.W(AW + JW), .DEPTH(QDEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_vld),
		.wr_data ({fr_addr, fr_job}),
		.rd_en   (issue),
		.rd_data (fq_data),
		.rd_vld  (fq_vld)
	);

	glgs_back #(.N(N), .AW(AW)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_vld        (fq_vld),
		.job_addr       (fq_data[AW+JW-1:JW]),
		.job            (glgs_job_t'(fq_data[JW-1:0])),
		.min_biomass    (minb_q),
		.issue          (issue),
		.clearing       (clearing),
		.out_vld        (out_vld),
		.pop            (pop),
		.new_biomass    (new_biomass),
		.light_response (light_response)
	);

	assign empty = !out_vld;

endmodule

// ----- hdl/glgs_checker.sv -----
module glgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [23:0] new_biomass,
	input logic [15:0] light_response
);

	// a waiting result only goes away through a pop
	a_drain_by_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result dropped without pop");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(new_biomass) && $stable(light_response)))
		else $error("stalled result changed");

	a_resp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (light_response <= 16'd32768))
		else $error("light response above one");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({new_biomass, light_response}))
		else $error("result has unknown bits");

endmodule

bind grid_logistic_growth_step_top glgs_checker u_glgs_checker (.*);

// ----- bench/grid_logistic_growth_step_top_tb.sv -----
module grid_logistic_growth_step_top_tb;
	import glgs_pkg::*;

	localparam int SIDE = 64;
	localparam int N_RANDOM = 1850;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [23:0] biomass;
		logic [15:0] resp;
	} growth_t;

	// Growth model: config copy, biomass store, queue of expected results.
	class growth_scoreboard;
		logic [15:0] temp_f, drought_f, rate_max;
		logic [23:0] cap_max, bio_floor;
		logic [2:0]  shade;
		logic [23:0] biomass [SIDE*SIDE];
		growth_t     pending [$];
		int          mismatches;
		int          checked;

		function void reset_state();
			temp_f = 32768;
			drought_f = 32768;
			cap_max = 1048576;
			rate_max = 32768;
			shade = 1;
			bio_floor = 1048;
			foreach (biomass[i]) biomass[i] = 1048;
			pending.delete();
		endfunction

		function void write_reg(reg_idx_t idx, logic [23:0] v);
			case (idx)
				REG_TEMP:     temp_f = v[15:0];
				REG_DROUGHT:  drought_f = v[15:0];
				REG_MAX_CAP:  cap_max = v;
				REG_MAX_RATE: rate_max = v[15:0];
				REG_SHADE:    shade = v[2:0];
				REG_MIN_BIO:  bio_floor = v;
				default: ;
			endcase
		endfunction

		// 2^-y approximation, y from slope*(light-ofs) in Q.30
		function longint pow2_decay(longint light, longint ofs, longint slope);
			longint tab [17] = '{32768, 31379, 30048, 28774, 27554, 26386, 25268,
				24196, 23170, 22188, 21247, 20347, 19484, 18658, 17867, 17109, 16384};
			longint p, yb, n, frac, i, rem, v;
			p = slope * (light - ofs) + (longint'(4) << 30);
			if (p < 0) p = 0;
			yb = p >> 15;
			n = yb >> 15;
			frac = yb & 'h7FFF;
			i = frac >> 11;
			rem = frac & 'h7FF;
			v = tab[i] - ((tab[i] - tab[i+1]) * rem) / 2048;
			if (n <= 4) return v * (longint'(1) << (4 - n));
			if (n - 4 > 20) return 0;
			return v / (longint'(1) << (n - 4));
		endfunction

		function longint light_curve(longint light);
			longint a, b, w, raw4, r;
			a = 52429 * (32768 - pow2_decay(light, 4915, 54838));
			b = 33115 * (32768 - pow2_decay(light, 983, 217461));
			w = shade;
			if (w < 1) w = 1;
			if (w > 5) w = 5;
			raw4 = 4 * a + (w - 1) * (b - a);
			if (raw4 <= 0) return 0;
			r = raw4 >> 17;
			return r > 32768 ? 32768 : r;
		endfunction

		function void note_input(logic [5:0] row, logic [5:0] col, logic [15:0] light);
			longint resp, env, kpot, reff, b, nb;
			growth_t g;
			resp = light_curve(light);
			env = (((longint'(temp_f) * drought_f) >> 15) * resp) >> 15;
			kpot = (longint'(cap_max) * env) >> 15;
			reff = (longint'(rate_max) * env) >> 15;
			g.resp = resp[15:0];
			if (row >= SIDE || col >= SIDE) begin
				g.biomass = 0;
			end else begin
				b = biomass[row*SIDE+col];
				nb = b;
				if (kpot > 0) nb = b + (reff * (((kpot - b) * b) / kpot)) / 32768;
				if (nb < 0) nb = 0;
				if (nb > 24'hFFFFFF) nb = 24'hFFFFFF;
				if (nb < bio_floor) nb = bio_floor;
				biomass[row*SIDE+col] = nb[23:0];
				g.biomass = nb[23:0];
			end
			pending.push_back(g);
		endfunction

		function void check_result(logic [23:0] bio, logic [15:0] resp);
			growth_t g;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: biomass %0d resp %0d", bio, resp);
				return;
			end
			g = pending.pop_front();
			if (bio !== g.biomass || resp !== g.resp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: biomass exp %0d got %0d, resp exp %0d got %0d",
						g.biomass, bio, g.resp, resp);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        pop = 0;
	logic [5:0]  cell_row = 0;
	logic [5:0]  cell_col = 0;
	logic [15:0] light_level = 0;
	logic        cfg_wr_en = 0;
	logic [2:0]  cfg_idx = 0;
	logic [23:0] cfg_wdata = 0;
	logic        full, empty;
	logic [23:0] new_biomass;
	logic [15:0] light_response;

	growth_scoreboard sb;
	longint cycles = 0;
	int     hold_off = 0;
	int     stall_mode = 0;
	bit     hold_req = 0;
	bit     hold_done = 0;

	grid_logistic_growth_step_top #(.GRID_SIDE(SIDE)) uut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("grid_logistic_growth_step_top regression: fail");
			$finish;
		end
	end

	// receiver: checks accepted results, stalls on its own pattern
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_result(new_biomass, light_response);
		if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_off <= 400;
			pop <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pop <= 0;
		end else begin
			case (stall_mode)
				0: pop <= 1;
				1: pop <= ($urandom_range(0, 3) != 0);
				default: pop <= ($urandom_range(0, 1) != 0);
			endcase
			if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
		end
	end

	task automatic send(logic [5:0] r, logic [5:0] c, logic [15:0] l);
		push <= 1;
		cell_row <= r;
		cell_col <= c;
		light_level <= l;
		do @(posedge clk); while (full);
		sb.note_input(r, c, l);
	endtask

	task automatic rest(int n);
		if (n > 0) begin
			push <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_cfg(reg_idx_t idx, logic [23:0] v);
		cfg_wr_en <= 1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	// mostly a small hot region so cells grow over many visits
	task automatic random_burst(int n);
		logic [15:0] l;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: l = 16'($urandom);
				1: l = 16'($urandom_range(0, 2000));
				default: l = 16'($urandom_range(0, 32768));
			endcase
			if ($urandom_range(0, 3) == 0)
				send(6'($urandom), 6'($urandom), l);
			else
				send(6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)), l);
			if ($urandom_range(0, 9) == 0) rest($urandom_range(1, 6));
		end
	endtask

	initial begin
		logic [23:0] cfgs [6];
		int sent;
		int burst_n;
		sb = new();
		sb.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: light extremes, same cell back to back, grid edge row/col
		send(0, 0, 0);
		send(0, 0, 16'hFFFF);
		send(0, 0, 32768);
		send(63, 63, 4915);
		send(63, 0, 983);
		send(0, 63, 16'h8001);
		send(1, 1, 16'h5555);
		send(1, 1, 16'hAAAA);
		send(2, 2, 1);
		drain();
		for (int s = 0; s < 8; s++) begin
			write_cfg(REG_SHADE, 24'(s));
			send(3, 6'(s), 8000);
			send(3, 6'(s), 32768);
			drain();
		end
		write_cfg(REG_MAX_CAP, 0);
		send(4, 4, 32768);
		drain();
		write_cfg(REG_MAX_CAP, 24'hFFFFFF);
		write_cfg(REG_MAX_RATE, 16'hFFFF);
		write_cfg(REG_MIN_BIO, 24'hFF0000);
		send(5, 5, 32768);
		send(5, 5, 32768);
		drain();

		// random phases through several register settings
		sent = 0;
		for (int ph = 0; sent < N_RANDOM; ph++) begin
			drain();
			cfgs[0] = (ph % 3 == 0) ? 24'd0 : (ph % 3 == 1) ? 24'd32768 :
				24'($urandom_range(0, 32768));
			cfgs[1] = (ph % 4 == 0) ? 24'd32768 : 24'($urandom_range(0, 32768));
			cfgs[2] = (ph % 5 == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 24'hFFFFFF));
			cfgs[3] = (ph % 2 == 0) ? 24'h00FFFF : 24'($urandom_range(0, 16'hFFFF));
			cfgs[4] = 24'($urandom_range(0, 7));
			cfgs[5] = (ph % 3 == 0) ? 24'd0 : 24'($urandom_range(0, 24'h00FFFF));
			for (int r = 0; r < 6; r++) write_cfg(reg_idx_t'(r), cfgs[r]);
			if (ph == 2) hold_req = 1;
			for (int b = 0; b < 6 && sent < N_RANDOM; b++) begin
				burst_n = $urandom_range(5, 40);
				if (burst_n > N_RANDOM - sent) burst_n = N_RANDOM - sent;
				random_burst(burst_n);
				sent += burst_n;
				rest($urandom_range(0, 8));
			end
		end
		drain();
		$display("covered directed light/shade/capacity corners and %0d random cells", sent);
		$display("%0d result transactions checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("grid_logistic_growth_step_top regression: pass");
		else
			$display("grid_logistic_growth_step_top regression: fail");
		$finish;
	end
endmodule
